// File: src/bc_pkg.sv
// Shared constants and types for the binomial coefficient block.
package bc_pkg;
	localparam int N_BITS = 8;
	localparam int FIELD_W = 8;
	localparam int NW = (N_BITS < FIELD_W) ? N_BITS : FIELD_W;
	localparam int CW = 63;
	localparam int PW = CW + NW;
	localparam int CNT_W = $clog2(CW);

	typedef logic [CW-1:0] coef_t;
	typedef logic [NW-1:0] num_t;
endpackage

// File: src/bc_div.sv
// Radix-2 restoring divider: one quotient bit per cycle.
module bc_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  bc_pkg::coef_t   dividend,
	input  bc_pkg::num_t    divisor,
	output logic            done,
	output bc_pkg::coef_t   quotient
);
	logic                     busy_q;
	logic                     done_q;
	logic [bc_pkg::CNT_W-1:0] cnt_q;
	bc_pkg::coef_t            quo_q;
	bc_pkg::num_t             rem_q;
	bc_pkg::num_t             dvs_q;
	logic [bc_pkg::NW:0]      trial;
	logic [bc_pkg::NW:0]      diff;
	logic                     ge;

	assign trial = {rem_q, quo_q[bc_pkg::CW-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == bc_pkg::CNT_W'(bc_pkg::CW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[bc_pkg::CW-2:0], ge};
			rem_q <= ge ? diff[bc_pkg::NW-1:0] : trial[bc_pkg::NW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// File: src/binomial_coefficient.sv
// Binomial coefficient C(n,k), multiplicative scheme, with one serial divider.
//
// channel | direction | handshake           | payload
// in      | into      | in_valid / in_stall  | count_n, choose_k
// out     | out of    | out_valid / out_stall| coefficient, overflow
//
// Trivial cases (k = 0, k = n, k > n, reduced k = 1) go straight to the result.
// Otherwise each of the reduced k iterations, k <= 127, has a multiply step
// followed by a bit-serial divide of the product by the iteration index.
// An overflowing product ends the item at once with coefficient 0.
// Reset clears the sequencer and the output valid; in_stall is high while
// an item is in work or its result waits for a stalled output register.
module binomial_coefficient (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            count_n,
	input  logic [7:0]            choose_k,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [bc_pkg::CW-1:0] coefficient,
	output logic                  overflow
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]          state_q;
	bc_pkg::num_t        i_q;
	bc_pkg::num_t        kr_q;
	bc_pkg::num_t        base_q;
	bc_pkg::coef_t       acc_q;
	logic                ovf_q;
	logic                out_valid_q;
	bc_pkg::coef_t       coef_q;
	logic                oflag_q;

	bc_pkg::num_t        n_in;
	bc_pkg::num_t        k_in;
	bc_pkg::num_t        nk_in;
	bc_pkg::num_t        kr_in;
	bc_pkg::num_t        mul;
	logic [bc_pkg::PW-1:0] prod;
	logic                prod_ovf;
	logic                accept;
	logic                div_start;
	logic                div_done;
	bc_pkg::coef_t       div_quo;
	logic                out_load;

	assign n_in   = count_n[bc_pkg::NW-1:0];
	assign k_in   = choose_k[bc_pkg::NW-1:0];
	assign nk_in  = n_in - k_in;
	assign kr_in  = (k_in > nk_in) ? nk_in : k_in;
	assign accept = in_valid && !in_stall;

	assign mul      = base_q + i_q;
	assign prod     = bc_pkg::PW'(acc_q) * bc_pkg::PW'(mul);
	assign prod_ovf = |prod[bc_pkg::PW-1:bc_pkg::CW];
	assign div_start = (state_q == ST_MUL) && !prod_ovf;
	assign out_load  = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	bc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod[bc_pkg::CW-1:0]),
		.divisor  (i_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (k_in == '0 || k_in == n_in || k_in > n_in || kr_in == 1) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					state_q <= prod_ovf ? ST_FIN : ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= (i_q == kr_q) ? ST_FIN : ST_MUL;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				i_q    <= bc_pkg::NW'(1);
				kr_q   <= kr_in;
				base_q <= n_in - kr_in;
				ovf_q  <= 1'b0;
				priority if (k_in == '0 || k_in == n_in) begin
					acc_q <= bc_pkg::CW'(1);
				end else if (k_in > n_in) begin
					acc_q <= '0;
				end else if (kr_in == 1) begin
					acc_q <= bc_pkg::CW'(n_in);
				end else begin
					acc_q <= bc_pkg::CW'(1);
				end
			end
			ST_MUL: begin
				if (prod_ovf) begin
					ovf_q <= 1'b1;
					acc_q <= '0;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					acc_q <= div_quo;
					i_q   <= i_q + 1'b1;
				end
			end
			ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			coef_q  <= acc_q;
			oflag_q <= ovf_q;
		end
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = out_valid_q;
	assign coefficient = coef_q;
	assign overflow    = oflag_q;

`ifndef SYNTHESIS
	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> coefficient == '0)
		else $error("overflow beat with nonzero coefficient");
	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside divide state");
	a_iter_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |-> i_q != '0 && i_q <= kr_q)
		else $error("iteration index out of range");
	a_accept_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("accepted beat did not start work");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> state_q == ST_FIN && !(out_valid_q && out_stall))
		else $error("output register overwritten while stalled");
`endif
endmodule

// File: verif/tb.sv
// Testbench for the binomial coefficient block: directed and random n,k, self-checking.
`timescale 1ns / 1ps

module tb;
	localparam bit [63:0] COEF_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam int CYCLE_LIMIT = 8_000_000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS = 74;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_stall;
	logic [7:0]    count_n = '0;
	logic [7:0]    choose_k = '0;
	logic          out_valid;
	logic          out_stall = 1'b0;
	bc_pkg::coef_t coefficient;
	logic          overflow;

	bc_pkg::coef_t coef_expect_q[$];
	logic          ovf_expect_q[$];
	int            fail_count = 0;
	int            cycle_count = 0;
	int            stall_mode = 0;
	bit            hold_req = 1'b0;
	int            hold_left = 0;

	binomial_coefficient i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.count_n    (count_n),
		.choose_k   (choose_k),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.coefficient(coefficient),
		.overflow   (overflow)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Multiplicative C(n,k) with the pre-multiply overflow test.
	function automatic void calc_binomial(input logic [7:0] n_in, input logic [7:0] k_in,
			output bc_pkg::coef_t coef, output logic ovf);
		bit [63:0] mask;
		bit [63:0] n;
		bit [63:0] k;
		bit [63:0] acc;
		bit [63:0] mul;
		bit [63:0] i;
		mask = (64'd1 << bc_pkg::N_BITS) - 64'd1;
		n = 64'(n_in) & mask;
		k = 64'(k_in) & mask;
		acc = 64'd1;
		ovf = 1'b0;
		if (k == 0 || k == n) begin
			acc = 64'd1;
		end else if (k > n) begin
			acc = 64'd0;
		end else begin
			if (k > n - k)
				k = n - k;
			if (k == 1) begin
				acc = n;
			end else begin
				for (i = 1; i <= k; i++) begin
					mul = n - k + i;
					if (acc > COEF_MAX / mul) begin
						ovf = 1'b1;
						acc = 64'd0;
						break;
					end
					acc = acc * mul;
					acc = acc / i;
				end
			end
		end
		coef = acc[bc_pkg::CW-1:0];
	endfunction

	// Receiver stall pattern; a hold request stalls for a long counted stretch.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= $urandom_range(0, 1);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (coef_expect_q.size() == 0) begin
				$error("unexpected result beat: coefficient %0d overflow %0b",
					coefficient, overflow);
				fail_count++;
			end else begin
				if (coefficient !== coef_expect_q[0]) begin
					$error("coefficient: expected %0d, got %0d", coef_expect_q[0], coefficient);
					fail_count++;
				end
				if (overflow !== ovf_expect_q[0]) begin
					$error("overflow: expected %0b, got %0b", ovf_expect_q[0], overflow);
					fail_count++;
				end
				void'(coef_expect_q.pop_front());
				void'(ovf_expect_q.pop_front());
			end
		end
	end

	task automatic send_item(input logic [7:0] n, input logic [7:0] k);
		bc_pkg::coef_t c;
		logic          o;
		in_valid <= 1'b1;
		count_n <= n;
		choose_k <= k;
		do @(posedge clk); while (in_stall);
		calc_binomial(n, k, c, o);
		coef_expect_q.push_back(c);
		ovf_expect_q.push_back(o);
	endtask

	task automatic idle_in(input int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (coef_expect_q.size() != 0) @(posedge clk);
	endtask

	task automatic test_trivial();
		stall_mode = 0;
		send_item(8'd0, 8'd0);
		send_item(8'd255, 8'd255);
		send_item(8'd255, 8'd0);
		send_item(8'd0, 8'd255);
		send_item(8'd254, 8'd255);
		send_item(8'd3, 8'd200);
		send_item(8'd255, 8'd1);
		send_item(8'd255, 8'd254);
		send_item(8'd2, 8'd1);
		wait_drained();
	endtask

	task automatic test_multiplicative();
		stall_mode = 1;
		send_item(8'd10, 8'd5);
		send_item(8'd66, 8'd33);
		send_item(8'd62, 8'd31);
		send_item(8'd60, 8'd30);
		idle_in(3);
		send_item(8'd40, 8'd20);
		send_item(8'd255, 8'd127);
		send_item(8'd255, 8'd2);
		send_item(8'd128, 8'd64);
		idle_in(1);
		send_item(8'd130, 8'd3);
		send_item(8'd170, 8'd85);
		send_item(8'd67, 8'd34);
		wait_drained();
	endtask

	task automatic test_backpressure();
		stall_mode = 0;
		hold_req = 1'b1;
		send_item(8'd7, 8'd0);
		send_item(8'd9, 8'd9);
		send_item(8'd4, 8'd5);
		send_item(8'd12, 8'd1);
		send_item(8'd6, 8'd3);
		send_item(8'd200, 8'd199);
		wait_drained();
	endtask

	task automatic pick_pair(output logic [7:0] n, output logic [7:0] k);
		int sel;
		int nv;
		sel = $urandom_range(0, 9);
		nv = $urandom_range(0, 255);
		if (sel < 5) begin
			nv = $urandom_range(0, 70);
			n = nv[7:0];
			k = 8'($urandom_range(0, nv + 2));
		end else if (sel < 7) begin
			n = 8'($urandom);
			k = 8'($urandom);
		end else if (sel == 7) begin
			n = nv[7:0];
			case ($urandom_range(0, 3))
				0: k = 8'd0;
				1: k = 8'd1;
				2: k = n;
				default: k = n - 8'd1;
			endcase
		end else begin
			n = nv[7:0];
			k = 8'($urandom_range(2, 6));
		end
	endtask

	task automatic test_random();
		logic [7:0] n;
		logic [7:0] k;
		int burst_left;
		burst_left = 0;
		for (int idx = 0; idx < RANDOM_ITEMS; idx++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 8);
				stall_mode = $urandom_range(0, 2);
				if ($urandom_range(0, 2) != 0)
					idle_in($urandom_range(1, 6));
			end
			pick_pair(n, k);
			send_item(n, k);
			burst_left--;
		end
		wait_drained();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_trivial();
		test_multiplicative();
		test_backpressure();
		test_random();
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
